FILE: design/far_pkg.sv
// Shared types for the fraction add-and-reduce block.
// Holds the sequencer state encoding and the status bundle of the bit-serial units.
// No dependencies.
`default_nettype none

package far_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SIGN,
    ST_SUM,
    ST_CHECK,
    ST_ABS,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_DIVD_START,
    ST_DIVD_WAIT,
    ST_FINAL,
    ST_OUT
  } far_state_t;

  // Status of a bit-serial arithmetic unit; done pulses for one cycle.
  typedef struct packed {
    logic busy;
    logic done;
  } far_unit_stat_t;

endpackage

`default_nettype wire

FILE: design/far_mul.sv
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on far_pkg for the unit status type.
`default_nettype none

module far_mul #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        multiplicand,
  input  logic [WIDTH-1:0]        multiplier,
  output logic [2*WIDTH-1:0]      product,
  output far_pkg::far_unit_stat_t stat
);
  import far_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] count;
  logic [WIDTH-1:0] mcand;
  logic [WIDTH-1:0] mplier;
  logic             busy;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  // Multiplier bits are consumed from the top, so the product shifts left each step.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= multiplicand;
      mplier  <= multiplier;
      product <= '0;
    end else if (busy) begin
      product <= {product[2*WIDTH-2:0], 1'b0} +
                 (mplier[WIDTH-1] ? {{WIDTH{1'b0}}, mcand} : '0);
      mplier  <= {mplier[WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: design/far_div.sv
// Bit-serial restoring divider for unsigned words, one quotient bit per cycle.
// Depends on far_pkg for the unit status type.
`default_nettype none

module far_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        dividend,
  input  logic [WIDTH-1:0]        divisor,
  output logic [WIDTH-1:0]        quotient,
  output logic [WIDTH-1:0]        remainder,
  output far_pkg::far_unit_stat_t stat
);
  import far_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] count;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   trial;
  logic             fits;
  logic             busy;
  logic             done;

  // The quotient register starts out holding the dividend and shifts it out from the top.
  assign trial = {remainder, quotient[WIDTH-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      remainder <= fits ? WIDTH'(trial - {1'b0, dsr}) : trial[WIDTH-1:0];
      quotient  <= {quotient[WIDTH-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: design/fraction_add_and_reduce.sv
// Top level of the fraction add-and-reduce block: sequencer and datapath.
// Depends on far_pkg, far_mul and far_div.
//
// Takes numerator, denominator and integer addend, forms numerator + addend * denominator
// over the denominator, reduces it by the greatest common divisor and returns the result
// with a positive denominator; zero sums give 0/1. A zero denominator sets divide_error,
// a sum or reduced result outside the signed DATA_WIDTH range sets overflow, and both
// cases return 0/1. One item is handled at a time and the input is not ready until the
// result transfer completes. The product comes from a bit-serial multiplier, and every
// Euclid remainder step and both final divisions share one bit-serial divider. A zero
// denominator goes straight from the idle state to the output state.
`default_nettype none

module fraction_add_and_reduce #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: numerator_in, denominator_in, addend, zero fill.
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0 up: numerator_out, denominator_out, zero fill.
  output logic [((2*DATA_WIDTH+6)/8)*8-1:0] m_tdata,
  // Fields from bit 0 up: divide_error, overflow.
  output logic [1:0] m_tuser
);
  import far_pkg::*;

  localparam int unsigned DW         = DATA_WIDTH;
  localparam int unsigned DEN_W      = DW - 1;
  localparam int unsigned OUT_W      = ((2*DATA_WIDTH+6)/8)*8;
  localparam int unsigned SW         = 2*DW + 2;
  // Products of 2^64 and above are rejected as out of range.
  localparam int unsigned BIG_SHIFT  = 64;
  localparam logic signed [SW-1:0] MAX_SUM = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_SUM = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  far_state_t state, state_next;

  logic [DW-1:0] n_raw, d_raw, a_raw;
  logic [DW-1:0] d_in_mag, a_in_mag;
  logic          accept;

  logic [DW-1:0]        n_word;
  logic                 d_neg;
  logic [DW-1:0]        d_mag;
  logic                 p_neg;
  logic                 big;
  logic signed [SW-1:0] psum;
  logic signed [SW-1:0] n_ext;
  logic [SW-1:0]        prod_ext;
  logic                 s_neg;
  logic [DW-1:0]        s_mag;
  logic [DW-1:0]        s_mag_next;
  logic [DW-1:0]        ga, gb;
  logic [DW-1:0]        num_q, den_q;
  logic                 r_neg;

  logic [2*DW-1:0] product;
  far_unit_stat_t  mul_stat;

  logic            div_start;
  logic [DW-1:0]   div_dividend, div_divisor;
  logic [DW-1:0]   div_quo, div_rem;
  far_unit_stat_t  div_stat;

  logic             res_load;
  logic [DW-1:0]    res_num, res_num_next;
  logic [DEN_W-1:0] res_den, res_den_next;
  logic             res_derr, res_derr_next;
  logic             res_ovf, res_ovf_next;

  assign n_raw = s_tdata[DW-1:0];
  assign d_raw = s_tdata[2*DW-1:DW];
  assign a_raw = s_tdata[3*DW-1:2*DW];

  assign d_in_mag = d_raw[DW-1] ? (~d_raw + 1'b1) : d_raw;
  assign a_in_mag = a_raw[DW-1] ? (~a_raw + 1'b1) : a_raw;

  // No transfer is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  far_mul #(.WIDTH(DW)) u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .multiplicand (d_in_mag),
    .multiplier   (a_in_mag),
    .product      (product),
    .stat         (mul_stat)
  );

  // The divider serves the Euclid remainders and both final divisions by the greatest common divisor.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = d_mag;
    div_divisor  = ga;
    case (state)
      ST_GCD_START: begin
        div_start    = (gb != '0);
        div_dividend = ga;
        div_divisor  = gb;
      end
      ST_DIVN_START: begin
        div_start    = 1'b1;
        div_dividend = s_mag;
      end
      ST_DIVD_START: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  far_div #(.WIDTH(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign prod_ext   = {2'b00, product};
  assign n_ext      = {{(SW-DW){n_word[DW-1]}}, n_word};
  assign s_mag_next = psum[SW-1] ? (~psum[DW-1:0] + 1'b1) : psum[DW-1:0];
  assign r_neg      = s_neg ^ d_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    res_load      = 1'b0;
    res_num_next  = '0;
    res_den_next  = DEN_W'(1);
    res_derr_next = 1'b0;
    res_ovf_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (d_raw == '0) begin
            res_load      = 1'b1;
            res_derr_next = 1'b1;
            state_next    = ST_OUT;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: state_next = ST_SUM;
      ST_SUM:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (big || (psum > MAX_SUM) || (psum < MIN_SUM)) begin
          res_load     = 1'b1;
          res_ovf_next = 1'b1;
          state_next   = ST_OUT;
        end else if (psum == '0) begin
          res_load   = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_ABS;
        end
      end
      ST_ABS: state_next = ST_GCD_START;
      ST_GCD_START: begin
        state_next = (gb == '0) ? ST_DIVN_START : ST_GCD_WAIT;
      end
      ST_GCD_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_GCD_START;
        end
      end
      ST_DIVN_START: state_next = ST_DIVN_WAIT;
      ST_DIVN_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_DIVD_START;
        end
      end
      ST_DIVD_START: state_next = ST_DIVD_WAIT;
      ST_DIVD_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        res_load = 1'b1;
        // Only a most negative denominator or sum can leave the reduced parts out of range.
        if (den_q[DW-1] || (!r_neg && num_q[DW-1])) begin
          res_ovf_next = 1'b1;
        end else begin
          res_num_next = r_neg ? (~num_q + 1'b1) : num_q;
          res_den_next = den_q[DEN_W-1:0];
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          n_word <= n_raw;
          d_neg  <= d_raw[DW-1];
          d_mag  <= d_in_mag;
          p_neg  <= a_raw[DW-1] ^ d_raw[DW-1];
        end
      end
      ST_SIGN: begin
        big  <= (product >> BIG_SHIFT) != '0;
        psum <= p_neg ? (SW'(0) - prod_ext) : prod_ext;
      end
      ST_SUM: psum <= psum + n_ext;
      ST_ABS: begin
        s_neg <= psum[SW-1];
        s_mag <= s_mag_next;
        ga    <= s_mag_next;
        gb    <= d_mag;
      end
      ST_GCD_WAIT: begin
        if (div_stat.done) begin
          ga <= gb;
          gb <= div_rem;
        end
      end
      ST_DIVN_WAIT: begin
        if (div_stat.done) begin
          num_q <= div_quo;
        end
      end
      ST_DIVD_WAIT: begin
        if (div_stat.done) begin
          den_q <= div_quo;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_num  <= res_num_next;
      res_den  <= res_den_next;
      res_derr <= res_derr_next;
      res_ovf  <= res_ovf_next;
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(OUT_W-2*DW+1){1'b0}}, res_den, res_num};
  assign m_tuser  = {res_ovf, res_derr};

`ifndef SYNTHESIS
  a_zero_den_fast: assert property (@(posedge clk) disable iff (rst)
    (accept && (d_raw == '0)) |=> (m_tvalid && m_tuser[0]))
    else $error("zero denominator did not return an error result at once");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("divide error and overflow flagged together");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0] && !m_tuser[1]) |-> (res_den != '0))
    else $error("clean result carries a zero denominator");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN_START) |-> (ga != '0))
    else $error("greatest common divisor is zero");
  a_div_idle_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !div_stat.busy)
    else $error("divider still busy while the result is offered");
`endif

endmodule

`default_nettype wire
